### sv/hpa_pkg.sv
package hpa_pkg;

	localparam int POOL_SIZE = 256;
	localparam int HANDLE_W  = (POOL_SIZE > 2) ? $clog2(POOL_SIZE) : 1;
	localparam int CNT_W     = HANDLE_W + 1;
	localparam int IO_HW     = 8;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_TRY   = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_INVALID   = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [CNT_W-1:0]    count_t;

	function automatic handle_t next_pos(input handle_t p);
		next_pos = (p == HANDLE_W'(POOL_SIZE - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

### sv/hpa_ram.sv
module hpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/handle_pool_allocator_top.sv
// Handle allocator with a FIFO free list. Each request beat (opcode on s_tuser:
// allocate, try-allocate, deallocate) yields exactly one result beat (handle on
// m_tdata, status on m_tuser). The busy map and the free queue are read when a
// request is accepted and written back when it moves to the result register,
// which waits while that register is full and not drained; no new request is
// accepted until then. After reset the busy map is cleared by a pass over all
// POOL_SIZE (256) entries with s_tready low. Allocate reuses the oldest freed
// handle, else issues a fresh one, and reports exhausted when none are left.
module handle_pool_allocator_top
	import hpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] handle_in
	input  logic [1:0] s_tuser,   // [1:0] opcode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] handle_out
	output logic [1:0] m_tuser    // [1:0] status
);

	logic    clr_done_q;
	handle_t clr_q;
	handle_t head_q, tail_q;
	count_t  qcount_q, fresh_q;

	logic    s1_valid_q;
	op_t     op_s1;
	handle_t hin_s1;
	logic    hin_ok_s1;

	logic       out_valid_q;
	logic [7:0] out_handle_q;
	status_t    out_status_q;

	logic    accept, s1_fire;
	logic    busy_rd;
	handle_t q_rd;

	logic    busy_we, busy_wd;
	handle_t busy_wa;
	logic    q_we;

	logic    res_pop, res_fresh, res_free;
	handle_t res_h;
	status_t res_st;

	assign s_tready = clr_done_q && !s1_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign s1_fire  = s1_valid_q && (!out_valid_q || m_tready);

	always_comb begin
		res_pop   = 1'b0;
		res_fresh = 1'b0;
		res_free  = 1'b0;
		res_h     = '0;
		res_st    = ST_OK;
		unique case (op_s1)
			OP_ALLOC: begin
				if (qcount_q != '0) begin
					res_pop = 1'b1;
					res_h   = q_rd;
				end else if (fresh_q < count_t'(POOL_SIZE)) begin
					res_fresh = 1'b1;
					res_h     = HANDLE_W'(fresh_q);
				end else begin
					res_st = ST_EXHAUSTED;
				end
			end
			OP_TRY: begin
				if (qcount_q != '0) begin
					res_pop = 1'b1;
					res_h   = q_rd;
				end else begin
					res_st = ST_EMPTY;
				end
			end
			OP_FREE: begin
				if (hin_ok_s1 && busy_rd && qcount_q < count_t'(POOL_SIZE)) begin
					res_free = 1'b1;
				end else begin
					res_st = ST_INVALID;
				end
			end
			default: begin
				res_st = ST_INVALID;
			end
		endcase
	end

	always_comb begin
		if (!clr_done_q) begin
			busy_we = 1'b1;
			busy_wa = clr_q;
			busy_wd = 1'b0;
		end else begin
			busy_we = s1_fire && (res_pop || res_fresh || res_free);
			busy_wa = res_free ? hin_s1 : res_h;
			busy_wd = !res_free;
		end
	end

	assign q_we = s1_fire && res_free;

	hpa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_busy (
		.clk   (clk),
		.we    (busy_we),
		.waddr (busy_wa),
		.wdata (busy_wd),
		.re    (accept),
		.raddr (HANDLE_W'(s_tdata)),
		.rdata (busy_rd)
	);

	hpa_ram #(.WIDTH(HANDLE_W), .DEPTH(POOL_SIZE)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q),
		.wdata (hin_s1),
		.re    (accept),
		.raddr (head_q),
		.rdata (q_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_done_q  <= 1'b0;
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			qcount_q    <= '0;
			fresh_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!clr_done_q) begin
				clr_q <= next_pos(clr_q);
				if (clr_q == HANDLE_W'(POOL_SIZE - 1)) begin
					clr_done_q <= 1'b1;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				if (res_pop) begin
					head_q   <= next_pos(head_q);
					qcount_q <= qcount_q - 1'b1;
				end
				if (res_free) begin
					tail_q   <= next_pos(tail_q);
					qcount_q <= qcount_q + 1'b1;
				end
				if (res_fresh) begin
					fresh_q <= fresh_q + 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_t'(s_tuser);
			hin_s1    <= HANDLE_W'(s_tdata);
			hin_ok_s1 <= (CNT_W + IO_HW)'(s_tdata) < (CNT_W + IO_HW)'(POOL_SIZE);
		end
		if (s1_fire) begin
			out_handle_q <= IO_HW'(res_h);
			out_status_q <= res_st;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_handle_q;
	assign m_tuser  = out_status_q;

endmodule
